/* hw/rtl/fsp_pkg.sv */
// Shared types, character codes and helpers for the format specifier parser.
// No dependencies; used by fsp_step and format_spec_parser.
`timescale 1ns / 1ps

package fsp_pkg;

  // Internal number width for run, width and precision accumulators
  localparam int NUM_BITS = 16;
  localparam int ACC_W    = NUM_BITS + 4;
  localparam logic [NUM_BITS-1:0] NUM_MAX = '1;
  localparam logic [31:0] OUT_MAX = 32'd65535;

  // Configuration register indexes
  localparam logic REG_DEFAULT_PRECISION = 1'b0;
  localparam logic [15:0] DEF_PREC_RESET = 16'd6;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_G_UP   = 8'h47;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RUN    = 3'd1,
    PH_FLAGS  = 3'd2,
    PH_WIDTH  = 3'd3,
    PH_AFTERW = 3'd4,
    PH_PREC   = 3'd5,
    PH_LPEND  = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    CT_NONE   = 4'd0,
    CT_INT    = 4'd1,
    CT_CHAR   = 4'd2,
    CT_STRING = 4'd3,
    CT_FLOAT  = 4'd4,
    CT_DOUBLE = 4'd5,
    CT_LONG   = 4'd6,
    CT_ULONG  = 4'd7,
    CT_HEX_LO = 4'd8,
    CT_HEX_UP = 4'd9
  } conv_t;

  // flags: bit0 zero fill, bit1 show sign, bit2 left adjust
  typedef struct packed {
    phase_t              phase;
    logic [NUM_BITS-1:0] run_val;
    logic                run_nz;
    logic                run_lz;
    logic [NUM_BITS-1:0] pos;
    logic [2:0]          flags;
    logic [NUM_BITS-1:0] width;
    logic [NUM_BITS-1:0] prec;
    conv_t               ctype;
    logic [7:0]          count;
  } parse_state_t;

  typedef struct packed {
    logic [15:0] arg_position;
    logic        zero_fill;
    logic        show_sign;
    logic        left_adjust;
    logic [15:0] field_width;
    logic [15:0] prec_value;
    logic [3:0]  conv_type;
    logic [7:0]  consumed;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // v*10 + digit, saturating at NUM_MAX
  function automatic logic [NUM_BITS-1:0] accum(input logic [NUM_BITS-1:0] v,
                                                input logic [7:0] c);
    logic [ACC_W-1:0] r;
    r = (ACC_W'(v) << 3) + (ACC_W'(v) << 1) + ACC_W'(c[3:0]);
    if (r > ACC_W'(NUM_MAX)) return NUM_MAX;
    return r[NUM_BITS-1:0];
  endfunction

  function automatic logic [15:0] clamp_out(input logic [NUM_BITS-1:0] v);
    if (32'(v) > OUT_MAX) return 16'hFFFF;
    return 16'(32'(v));
  endfunction

  function automatic logic [7:0] count_add(input logic [7:0] cnt, input logic [1:0] n);
    logic [8:0] r;
    r = {1'b0, cnt} + 9'(n);
    if (r > 9'd255) return 8'd255;
    return r[7:0];
  endfunction

endpackage

/* hw/rtl/fsp_step.sv */
// Combinational parse step: one character against the current parse state.
// Depends on fsp_pkg.
`timescale 1ns / 1ps

module fsp_step import fsp_pkg::*; (
  input  parse_state_t cur,
  input  logic [7:0]   ch,
  input  logic         start_req,
  input  logic [15:0]  default_prec,
  output parse_state_t nxt,
  output logic         emit,
  output result_t      res
);

  parse_state_t st;
  logic         done;
  logic         fin;
  logic [3:0]   tcode;
  logic         tvalid;

  // single type characters
  always_comb begin
    tvalid = 1'b1;
    tcode  = CT_NONE;
    unique case (ch)
      CH_D, CH_I: tcode = CT_INT;
      CH_C:       tcode = CT_CHAR;
      CH_S:       tcode = CT_STRING;
      CH_F:       tcode = CT_FLOAT;
      CH_X:       tcode = CT_HEX_LO;
      CH_X_UP:    tcode = CT_HEX_UP;
      CH_O, CH_U, CH_E, CH_E_UP, CH_G, CH_G_UP, CH_P: tcode = CT_NONE;
      default:    tvalid = 1'b0;
    endcase
  end

  always_comb begin
    st   = cur;
    done = 1'b0;
    fin  = 1'b0;
    if (start_req) begin
      st.phase   = PH_RUN;
      st.run_val = '0;
      st.run_nz  = 1'b0;
      st.run_lz  = 1'b0;
      st.pos     = '0;
      st.flags   = 3'b000;
      st.width   = '0;
      st.prec    = NUM_BITS'(32'(default_prec));
      st.ctype   = CT_NONE;
      st.count   = 8'd0;
    end
    if (st.phase == PH_IDLE) done = 1'b1;

    // leading digit run: position or fill+width
    if (!done && st.phase == PH_RUN) begin
      if (is_digit(ch)) begin
        st.run_val = accum(st.run_val, ch);
        if (ch != CH_0) st.run_nz = 1'b1;
        else if (!st.run_nz) st.run_lz = 1'b1;
        st.count = count_add(st.count, 2'd1);
        done = 1'b1;
      end else if (!st.run_nz && !st.run_lz) begin
        st.phase = PH_FLAGS;
      end else if (ch == CH_DOLLAR) begin
        st.pos   = st.run_val;
        st.count = count_add(st.count, 2'd1);
        st.phase = PH_FLAGS;
        done = 1'b1;
      end else begin
        if (st.run_lz) st.flags[0] = 1'b1;
        if (st.run_nz) begin
          st.width = st.run_val;
          st.phase = PH_AFTERW;
        end else begin
          st.phase = PH_FLAGS;
        end
      end
    end

    if (!done && st.phase == PH_FLAGS) begin
      if (ch == CH_0 || ch == CH_PLUS || ch == CH_MINUS) begin
        if (ch == CH_0)          st.flags[0] = 1'b1;
        else if (ch == CH_PLUS)  st.flags[1] = 1'b1;
        else                     st.flags[2] = 1'b1;
        st.count = count_add(st.count, 2'd1);
        done = 1'b1;
      end else if (ch >= CH_1 && ch <= CH_9) begin
        st.width = NUM_BITS'(ch[3:0]);
        st.count = count_add(st.count, 2'd1);
        st.phase = PH_WIDTH;
        done = 1'b1;
      end else begin
        st.phase = PH_AFTERW;
      end
    end

    if (!done && st.phase == PH_WIDTH) begin
      if (is_digit(ch)) begin
        st.width = accum(st.width, ch);
        st.count = count_add(st.count, 2'd1);
        done = 1'b1;
      end else begin
        st.phase = PH_AFTERW;
      end
    end

    if (!done && st.phase == PH_AFTERW) begin
      if (ch == CH_DOT) begin
        st.prec  = '0;
        st.count = count_add(st.count, 2'd1);
        st.phase = PH_PREC;
      end else if (ch == CH_L) begin
        st.phase = PH_LPEND;
      end else begin
        if (tvalid) begin
          st.ctype = conv_t'(tcode);
          st.count = count_add(st.count, 2'd1);
        end
        fin = 1'b1;
      end
      done = 1'b1;
    end

    if (!done && st.phase == PH_PREC) begin
      if (is_digit(ch)) begin
        st.prec  = accum(st.prec, ch);
        st.count = count_add(st.count, 2'd1);
      end else if (ch == CH_L) begin
        st.phase = PH_LPEND;
      end else begin
        if (tvalid) begin
          st.ctype = conv_t'(tcode);
          st.count = count_add(st.count, 2'd1);
        end
        fin = 1'b1;
      end
      done = 1'b1;
    end

    if (!done && st.phase == PH_LPEND) begin
      if (ch == CH_U || ch == CH_D || ch == CH_F) begin
        st.ctype = (ch == CH_U) ? CT_ULONG : (ch == CH_D) ? CT_LONG : CT_DOUBLE;
        st.count = count_add(st.count, 2'd2);
      end
      fin = 1'b1;
    end

    if (fin) st.phase = PH_IDLE;
  end

  assign nxt  = st;
  assign emit = fin;

  always_comb begin
    res.arg_position = clamp_out(st.pos);
    res.zero_fill    = st.flags[0];
    res.show_sign    = st.flags[1];
    res.left_adjust  = st.flags[2];
    res.field_width  = clamp_out(st.width);
    res.prec_value   = clamp_out(st.prec);
    res.conv_type    = st.ctype;
    res.consumed     = st.count;
  end

endmodule

/* hw/rtl/format_spec_parser.sv */
// Top level of the format specifier parser: handshakes, parse state, result skid.
// Depends on fsp_pkg and fsp_step.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// in_       in   in_valid / in_ready       in_ch[7:0], in_start_req
// out_      out  out_valid / out_ready     arg_position, flags, width, prec, type, consumed
// cfg (APB) in   psel, penable, pready=1   paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// One character beat per cycle while in_ready is high. The parse step is one
// combinational pass from the registered parse state and the accepted beat; a
// finished specifier enters the output register (the skid, if that is stalled)
// at the edge that accepts its last beat. A two-entry output (register plus skid)
// keeps in_ready high while one result waits; it drops only when both are full.
// Synchronous active-low reset clears parse state and sets precision to 6.

module format_spec_parser import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // character input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_start_req,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_arg_position,
  output logic        out_zero_fill,
  output logic        out_show_sign,
  output logic        out_left_adjust,
  output logic [15:0] out_field_width,
  output logic [15:0] out_prec_value,
  output logic [3:0]  out_conv_type,
  output logic [7:0]  out_consumed,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  parse_state_t state_r, state_nxt;
  logic [15:0]  def_prec_r;
  logic         out_valid_r, skid_valid_r;
  result_t      out_res_r, skid_res_r;
  logic         step_emit;
  result_t      step_res;
  logic         in_fire, out_fire, push;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEFAULT_PRECISION) ? {16'd0, def_prec_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_prec_r <= DEF_PREC_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_DEFAULT_PRECISION) begin
      def_prec_r <= pwdata[15:0];
    end
  end

  // ---------------- parse step ----------------
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign push     = in_fire && step_emit;

  fsp_step u_step (
    .cur          (state_r),
    .ch           (in_ch),
    .start_req    (in_start_req),
    .default_prec (def_prec_r),
    .nxt          (state_nxt),
    .emit         (step_emit),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= PH_IDLE;
      state_r.run_val <= '0;
      state_r.run_nz  <= 1'b0;
      state_r.run_lz  <= 1'b0;
      state_r.pos     <= '0;
      state_r.flags   <= 3'b000;
      state_r.width   <= '0;
      state_r.prec    <= NUM_BITS'(32'(DEF_PREC_RESET));
      state_r.ctype   <= CT_NONE;
      state_r.count   <= 8'd0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // ---------------- output register + skid ----------------
  // skid only fills while the output register holds a stalled result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) out_res_r <= skid_res_r;
      else if (push)    out_res_r <= step_res;
    end
    if (out_valid_r && !out_fire && push) skid_res_r <= step_res;
  end

  assign out_valid        = out_valid_r;
  assign out_arg_position = out_res_r.arg_position;
  assign out_zero_fill    = out_res_r.zero_fill;
  assign out_show_sign    = out_res_r.show_sign;
  assign out_left_adjust  = out_res_r.left_adjust;
  assign out_field_width  = out_res_r.field_width;
  assign out_prec_value   = out_res_r.prec_value;
  assign out_conv_type    = out_res_r.conv_type;
  assign out_consumed     = out_res_r.consumed;

  // ---------------- assertions ----------------
  // skid holds a result only behind a full output register
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid full with empty output register");

  // a beat with no open specifier and no start never yields a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_start_req && state_r.phase == PH_IDLE) |-> !step_emit)
    else $error("result from idle parser");

  // a finished specifier leaves the parser idle
  assert property (@(posedge clk) disable iff (!rst_n)
    push |=> state_r.phase == PH_IDLE)
    else $error("parser not idle after result");

  // a stalled result with a full skid blocks input
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && push) |=> !in_ready)
    else $error("input open while both result slots full");

endmodule

/* tb/tb_format_spec_parser.sv */
// Self-checking testbench for format_spec_parser: character beats in, one result per finished specifier.
// Depends on fsp_pkg (character codes, phase/conversion enums, result_t) and the RTL top.
`timescale 1ns / 1ps

module tb_format_spec_parser;
  import fsp_pkg::*;

  // Generous bound on simulation length, even at worst-case idling
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Register 0 (default precision) sits at byte address 4*0
  localparam logic [2:0] PREC_ADDR = {REG_DEFAULT_PRECISION, 2'b00};

  localparam logic [7:0] TYPE_CHARS [14] = '{CH_D, CH_I, CH_C, CH_S, CH_F, CH_X, CH_X_UP,
                                             CH_O, CH_U, CH_E, CH_E_UP, CH_G, CH_G_UP, CH_P};
  localparam logic [7:0] LONG_SUFFIX [3] = '{CH_U, CH_D, CH_F};

  // ---------------------------------------------------------------------------
  // Scoreboard: tracks the parse of the open specifier and queues finished ones
  // ---------------------------------------------------------------------------
  class spec_scoreboard;
    logic [15:0] dflt_prec = DEF_PREC_RESET;
    phase_t      stage = PH_IDLE;
    logic [15:0] run_acc = '0;
    logic        run_nonzero = 1'b0;
    logic        run_zero_lead = 1'b0;
    logic [15:0] arg_pos = '0;
    logic [2:0]  flag_bits = '0;   // [0] zero fill, [1] sign, [2] left adjust
    logic [15:0] width_acc = '0;
    logic [15:0] prec_acc = DEF_PREC_RESET;
    conv_t       kind = CT_NONE;
    logic [7:0]  n_used = '0;
    result_t     open_specs[$];
    int          errors = 0;

    function void set_default_precision(input logic [15:0] v);
      dflt_prec = v;
    endfunction

    function logic is_num(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
    endfunction

    // decimal shift-in, saturating at 16 bits
    function logic [15:0] shift_digit(input logic [15:0] v, input logic [7:0] c);
      int r;
      r = int'(v) * 10 + int'(c) - int'(CH_0);
      return (r > 65535) ? 16'hFFFF : 16'(r);
    endfunction

    function void bump(input int n);
      n_used = (int'(n_used) + n > 255) ? 8'd255 : 8'(int'(n_used) + n);
    endfunction

    function void close_spec();
      result_t r;
      r.arg_position = arg_pos;
      r.zero_fill    = flag_bits[0];
      r.show_sign    = flag_bits[1];
      r.left_adjust  = flag_bits[2];
      r.field_width  = width_acc;
      r.prec_value   = prec_acc;
      r.conv_type    = kind;
      r.consumed     = n_used;
      open_specs.push_back(r);
      stage = PH_IDLE;
    endfunction

    function void take_type(input conv_t t);
      kind = t;
      bump(1);
    endfunction

    // type position: 'l' waits for its partner, anything else closes the spec
    function void end_on_type(input logic [7:0] c);
      if (c == CH_L) begin
        stage = PH_LPEND;
      end else begin
        case (c)
          CH_D, CH_I: take_type(CT_INT);
          CH_C:       take_type(CT_CHAR);
          CH_S:       take_type(CT_STRING);
          CH_F:       take_type(CT_FLOAT);
          CH_X:       take_type(CT_HEX_LO);
          CH_X_UP:    take_type(CT_HEX_UP);
          CH_O, CH_U, CH_E, CH_E_UP, CH_G, CH_G_UP, CH_P: take_type(CT_NONE);
          default: ;
        endcase
        close_spec();
      end
    endfunction

    function void note_char(input logic [7:0] c, input logic s);
      bit again;
      if (s) begin
        run_acc       = '0;
        run_nonzero   = 1'b0;
        run_zero_lead = 1'b0;
        arg_pos       = '0;
        flag_bits     = '0;
        width_acc     = '0;
        prec_acc      = dflt_prec;
        kind          = CT_NONE;
        n_used        = '0;
        stage         = PH_RUN;
      end
      again = (stage != PH_IDLE);
      // a rejected character falls through to the next stage in the same beat
      while (again) begin
        again = 1'b0;
        case (stage)
          PH_RUN: begin
            if (is_num(c)) begin
              run_acc = shift_digit(run_acc, c);
              if (c != CH_0) run_nonzero = 1'b1;
              else if (!run_nonzero) run_zero_lead = 1'b1;
              bump(1);
            end else if (!run_nonzero && !run_zero_lead) begin
              stage = PH_FLAGS;
              again = 1'b1;
            end else if (c == CH_DOLLAR) begin
              arg_pos = run_acc;
              bump(1);
              stage = PH_FLAGS;
            end else begin
              // no '$': the run was zero flags plus a width
              if (run_zero_lead) flag_bits[0] = 1'b1;
              if (run_nonzero) begin
                width_acc = run_acc;
                stage = PH_AFTERW;
              end else begin
                stage = PH_FLAGS;
              end
              again = 1'b1;
            end
          end
          PH_FLAGS: begin
            if (c == CH_0) begin
              flag_bits[0] = 1'b1;
              bump(1);
            end else if (c == CH_PLUS) begin
              flag_bits[1] = 1'b1;
              bump(1);
            end else if (c == CH_MINUS) begin
              flag_bits[2] = 1'b1;
              bump(1);
            end else if (c >= CH_1 && c <= CH_9) begin
              width_acc = 16'(c - CH_0);
              bump(1);
              stage = PH_WIDTH;
            end else begin
              stage = PH_AFTERW;
              again = 1'b1;
            end
          end
          PH_WIDTH: begin
            if (is_num(c)) begin
              width_acc = shift_digit(width_acc, c);
              bump(1);
            end else begin
              stage = PH_AFTERW;
              again = 1'b1;
            end
          end
          PH_AFTERW: begin
            if (c == CH_DOT) begin
              prec_acc = '0;
              bump(1);
              stage = PH_PREC;
            end else begin
              end_on_type(c);
            end
          end
          PH_PREC: begin
            if (is_num(c)) prec_acc = shift_digit(prec_acc, c);
            if (is_num(c)) bump(1);
            else end_on_type(c);
          end
          PH_LPEND: begin
            if (c == CH_U) begin
              kind = CT_ULONG;
              bump(2);
            end else if (c == CH_D) begin
              kind = CT_LONG;
              bump(2);
            end else if (c == CH_F) begin
              kind = CT_DOUBLE;
              bump(2);
            end
            close_spec();
          end
          default: ;
        endcase
      end
    endfunction

    function void cmp(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (open_specs.size() == 0) begin
        $error("result beat with no specifier pending");
        errors++;
        return;
      end
      want = open_specs.pop_front();
      cmp("arg_position", want.arg_position, got.arg_position);
      cmp("zero_fill",    want.zero_fill,    got.zero_fill);
      cmp("show_sign",    want.show_sign,    got.show_sign);
      cmp("left_adjust",  want.left_adjust,  got.left_adjust);
      cmp("field_width",  want.field_width,  got.field_width);
      cmp("prec_value",   want.prec_value,   got.prec_value);
      cmp("conv_type",    want.conv_type,    got.conv_type);
      cmp("consumed",     want.consumed,     got.consumed);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = '0;
  logic        in_start_req = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_arg_position;
  logic        out_zero_fill;
  logic        out_show_sign;
  logic        out_left_adjust;
  logic [15:0] out_field_width;
  logic [15:0] out_prec_value;
  logic [3:0]  out_conv_type;
  logic [7:0]  out_consumed;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  format_spec_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_start_req     (in_start_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_arg_position (out_arg_position),
    .out_zero_fill    (out_zero_fill),
    .out_show_sign    (out_show_sign),
    .out_left_adjust  (out_left_adjust),
    .out_field_width  (out_field_width),
    .out_prec_value   (out_prec_value),
    .out_conv_type    (out_conv_type),
    .out_consumed     (out_consumed),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  spec_scoreboard sb = new();

  int unsigned beats_in = 0;      // accepted character beats, bumped at the edge
  int unsigned cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [7:0]  spec_chars[$];     // characters of the specifier about to be sent
  result_t     seen;

  // field order matches result_t
  assign seen = {out_arg_position, out_zero_fill, out_show_sign, out_left_adjust,
                 out_field_width, out_prec_value, out_conv_type, out_consumed};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitors sample at the rising edge; the input beat is noted before the
  // result check so a same-edge result would still find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_char(in_ch, in_start_req);
        beats_in <= beats_in + 1;
      end
      if (out_valid && out_ready) sb.check_result(seen);
    end
  end

  // Receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: all called and returning on a falling edge
  // ---------------------------------------------------------------------------

  // One character beat; random gaps first, then hold until the monitor counts it.
  task automatic send_beat(input logic [7:0] c, input logic s);
    int unsigned target;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_ch        <= c;
    in_start_req <= s;
    target = beats_in + 1;
    do @(negedge clk); while (beats_in != target);
  endtask

  task automatic send_chars();
    foreach (spec_chars[i]) send_beat(spec_chars[i], i == 0);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_beat(txt[i], i == 0);
  endtask

  // Drop valid, wait out every pending result, then cover the output latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.open_specs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready; only while the block is idle
  task automatic write_default_precision(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PREC_ADDR;
    pwdata  <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_default_precision(v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_flag();
    case ($urandom_range(2))
      0:       return CH_0;
      1:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  // Mostly well-formed: [N$] flags [width] [.prec] type, with occasional long
  // runs (saturation), dangling 'l', junk type, trailing junk and truncation.
  task automatic build_spec();
    int n;
    int pick;
    spec_chars.delete();
    if ($urandom_range(99) < 30) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 3);
      repeat (n) spec_chars.push_back(rand_digit());
      spec_chars.push_back(CH_DOLLAR);
    end
    n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    repeat (n) spec_chars.push_back(rand_flag());
    if ($urandom_range(1) == 1) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 3);
      repeat (n) spec_chars.push_back(rand_digit());
    end
    if ($urandom_range(99) < 40) begin
      spec_chars.push_back(CH_DOT);
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 3);
      repeat (n) spec_chars.push_back(rand_digit());
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      spec_chars.push_back(TYPE_CHARS[$urandom_range(13)]);
    end else if (pick < 85) begin
      spec_chars.push_back(CH_L);
      spec_chars.push_back(LONG_SUFFIX[$urandom_range(2)]);
    end else if (pick < 92) begin
      spec_chars.push_back(CH_L);
      spec_chars.push_back(8'($urandom_range(255)));
    end else begin
      spec_chars.push_back(8'($urandom_range(255)));
    end
    // trailing NUL or junk: ends an open spec, or is ignored when idle
    if ($urandom_range(99) < 15)
      spec_chars.push_back(($urandom_range(1) == 1) ? CH_NUL : 8'($urandom_range(255)));
    // cut short: left open, then abandoned by the next start
    if ($urandom_range(99) < 5) begin
      n = $urandom_range(1, spec_chars.size());
      while (spec_chars.size() > n) void'(spec_chars.pop_back());
    end
  endtask

  task automatic random_phase(input int n_chars);
    int sent;
    sent = 0;
    while (sent < n_chars) begin
      // noise: random characters, some of them with start set
      if ($urandom_range(99) < 8)
        repeat ($urandom_range(1, 4))
          send_beat(8'($urandom_range(255)), $urandom_range(99) < 30);
      build_spec();
      sent += spec_chars.size();
      send_chars();
    end
  endtask

  task automatic directed_specs();
    // every single-character type, coded or not
    foreach (TYPE_CHARS[i]) send_beat(TYPE_CHARS[i], 1'b1);
    send_text("ld");
    send_text("lu");
    send_text("lf");
    send_text("lq");                 // dangling l: neither l nor q consumed
    send_text("12$+-0012.34x");
    send_text("007d");               // zero run becomes fill flag plus width
    send_text("0$d");                // all-zero run with '$'
    send_text("99999$.99999999f");   // position and precision saturate
    send_text("+-0123456789X");      // width saturates
    send_text(".s");                 // bare dot gives precision 0
    send_text("z");                  // empty specifier
    send_beat(CH_NUL, 1'b1);         // NUL right after '%'
    send_text("42");                 // abandoned by the restart below
    send_text("c");
    send_beat(CH_P, 1'b0);           // nothing open: ignored
    // consumed count saturates: long flag string and long zero run
    spec_chars.delete();
    repeat (260) spec_chars.push_back(CH_PLUS);
    spec_chars.push_back(CH_D);
    send_chars();
    spec_chars.delete();
    repeat (260) spec_chars.push_back(CH_0);
    spec_chars.push_back(CH_I);
    send_chars();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset precision, light sender gaps, heavy receiver stalls
    send_idle_pct = 7;
    recv_idle_pct = 74;
    directed_specs();
    settle();

    write_default_precision(16'hFFFF);
    random_phase(75);
    settle();                        // sender holds off until every result is back
    random_phase(75);
    settle();

    write_default_precision(16'h0000);
    send_idle_pct = 74;
    recv_idle_pct = 7;
    random_phase(75);
    settle();

    write_default_precision(16'($urandom_range(1, 65534)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(75);
    settle();

    if (sb.errors == 0 && sb.open_specs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_step.sv
hw/rtl/format_spec_parser.sv
tb/tb_format_spec_parser.sv
